>>> rtl/core/cmu_pkg.sv
// ----------------------------------------------------------------------------
// cmu_pkg: shared types and constants for the collision manifold unit
// Payload structs for both channels and the context that rides the pipe.
// ----------------------------------------------------------------------------
`default_nettype none

package cmu_pkg;

  // Q1.30 unit value
  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  // Vector and root widths
  localparam int unsigned MAG_W  = 34;              // |offset| magnitude
  localparam int unsigned RAD_W  = 2 * MAG_W + 2;   // sum of squares, even
  localparam int unsigned ROOT_W = RAD_W / 2;       // floor sqrt width
  localparam int unsigned SQ_N   = ROOT_W;          // one root bit per stage
  localparam int unsigned Q_W    = 31;              // quotient bits (<= 1.0)
  localparam int unsigned DV_N   = Q_W;             // one quotient bit per stage

  // Test select
  localparam logic OP_CIRCLE = 1'b0;
  localparam logic OP_BOX    = 1'b1;

  typedef struct packed {
    logic               op;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic [30:0]        a_radius;
    logic [30:0]        b_radius;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_max_y;
  } cmu_in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] penetration;
  } cmu_out_t;

  // Per-item context carried alongside root and quotient
  typedef struct packed {
    logic               hit;
    logic               sx;      // sign of normal x
    logic               sy;      // sign of normal y
    logic [MAG_W-1:0]   mx;
    logic [MAG_W-1:0]   my;
    logic [32:0]        pen_r;   // radius term of the depth
    logic [30:0]        zpen;    // depth on zero distance
    logic signed [31:0] zx;      // normal on zero distance
    logic signed [31:0] zy;
  } cmu_ctx_t;

endpackage

`default_nettype wire

>>> rtl/core/collision_manifold_unit.sv
// ----------------------------------------------------------------------------
// collision_manifold_unit: 2D narrow-phase circle/circle and box/circle test
// Pipelined offset, clamp, squares, square root stages and
// restoring divider stages; one manifold per pair.
// ----------------------------------------------------------------------------
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+-------------------
//  in      | in_valid_i  | in_stall_o   | in_i  (cmu_in_t)
//  out     | out_valid_o | out_stall_i  | out_o (cmu_out_t)
//
// A pair can enter every cycle unless the pipe is stalled; its result passes
// four setup stages, one root bit per sqrt stage, a divider load register,
// one quotient bit per divider stage and the output register.
// Reset clears only the valid bits of the pipe; no state persists between pairs.
// A stalled output freezes the whole pipe and raises in_stall_o in that cycle.
`default_nettype none

module collision_manifold_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire cmu_pkg::cmu_in_t  in_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output cmu_pkg::cmu_out_t      out_o
);
  import cmu_pkg::*;

  // global advance
  logic en;
  logic out_v_q;
  assign en         = !(out_v_q && out_stall_i);
  assign in_stall_o = !en;

  // ---------------- stage 1: offsets and half extents ----------------
  logic               s1_v_q;
  logic               s1_op_q;
  logic signed [32:0] s1_nx_q, s1_ny_q;
  logic signed [31:0] s1_xe_q, s1_ye_q;
  logic [30:0]        s1_ra_q, s1_rb_q;
  logic signed [32:0] s1_nx_d, s1_ny_d, s1_wx, s1_wy, s1_hx, s1_hy;

  always_comb begin
    s1_nx_d = $signed({in_i.b_x[31], in_i.b_x}) - $signed({in_i.a_x[31], in_i.a_x});
    s1_ny_d = $signed({in_i.b_y[31], in_i.b_y}) - $signed({in_i.a_y[31], in_i.a_y});
    s1_wx   = $signed({in_i.box_max_x[31], in_i.box_max_x})
            - $signed({in_i.box_min_x[31], in_i.box_min_x});
    s1_wy   = $signed({in_i.box_max_y[31], in_i.box_max_y})
            - $signed({in_i.box_min_y[31], in_i.box_min_y});
    // halve toward zero
    s1_hx   = (s1_wx + $signed({32'd0, s1_wx[32]})) >>> 1;
    s1_hy   = (s1_wy + $signed({32'd0, s1_wy[32]})) >>> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q <= in_i.op;
      s1_nx_q <= s1_nx_d;
      s1_ny_q <= s1_ny_d;
      s1_xe_q <= s1_hx[31:0];
      s1_ye_q <= s1_hy[31:0];
      s1_ra_q <= in_i.a_radius;
      s1_rb_q <= in_i.b_radius;
    end
  end

  // ---------------- stage 2: clamp, face push, magnitudes ----------------
  logic               s2_v_q;
  logic               s2_op_q, s2_inside_q;
  logic [MAG_W-1:0]   s2_mx_q, s2_my_q;
  logic [32:0]        s2_r_q;
  cmu_ctx_t           s2_ctx_q;
  logic signed [34:0] nx35, ny35, xe35, ye35, tx, ty, cx, cy, vx, vy;
  logic [32:0]        anx, any;
  logic               in_box, xaxis, positive;
  cmu_ctx_t           s2_ctx_d;
  logic [32:0]        s2_r_d;

  always_comb begin
    nx35 = {{2{s1_nx_q[32]}}, s1_nx_q};
    ny35 = {{2{s1_ny_q[32]}}, s1_ny_q};
    xe35 = {{3{s1_xe_q[31]}}, s1_xe_q};
    ye35 = {{3{s1_ye_q[31]}}, s1_ye_q};
    // upper bound first, then lower bound
    tx = (nx35 < xe35) ? nx35 : xe35;
    cx = (tx > -xe35) ? tx : -xe35;
    ty = (ny35 < ye35) ? ny35 : ye35;
    cy = (ty > -ye35) ? ty : -ye35;
    in_box   = (cx == nx35) && (cy == ny35);
    anx      = s1_nx_q[32] ? 33'(-s1_nx_q) : 33'(s1_nx_q);
    any      = s1_ny_q[32] ? 33'(-s1_ny_q) : 33'(s1_ny_q);
    xaxis    = 1'b0;
    positive = 1'b0;
    // push an inside centre to the face on the axis of larger offset, ties to y
    if (in_box) begin
      xaxis = anx > any;
      if (xaxis) begin
        positive = cx > 35'sd0;
        cx       = positive ? xe35 : -xe35;
      end else begin
        positive = cy > 35'sd0;
        cy       = positive ? ye35 : -ye35;
      end
    end
    if (s1_op_q == OP_BOX) begin
      vx = nx35 - cx;
      vy = ny35 - cy;
    end else begin
      vx = nx35;
      vy = ny35;
    end

    s2_ctx_d     = '0;
    s2_ctx_d.mx  = vx[34] ? MAG_W'(-vx) : MAG_W'(vx);
    s2_ctx_d.my  = vy[34] ? MAG_W'(-vy) : MAG_W'(vy);
    if (s1_op_q == OP_BOX) begin
      s2_ctx_d.sx    = vx[34] ^ in_box;
      s2_ctx_d.sy    = vy[34] ^ in_box;
      s2_ctx_d.pen_r = {2'b00, s1_rb_q};
      s2_ctx_d.zpen  = s1_rb_q;
      s2_ctx_d.zx    = xaxis ? (positive ? ONE_Q30 : -ONE_Q30) : 32'sd0;
      s2_ctx_d.zy    = xaxis ? 32'sd0 : (positive ? ONE_Q30 : -ONE_Q30);
      s2_r_d         = {2'b00, s1_rb_q};
    end else begin
      s2_ctx_d.sx    = vx[34];
      s2_ctx_d.sy    = vy[34];
      s2_ctx_d.pen_r = {2'b00, s1_ra_q} + {2'b00, s1_rb_q};
      s2_ctx_d.zpen  = s1_ra_q;
      s2_ctx_d.zx    = ONE_Q30;
      s2_ctx_d.zy    = 32'sd0;
      s2_r_d         = {2'b00, s1_ra_q} + {2'b00, s1_rb_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_op_q     <= s1_op_q;
      s2_inside_q <= in_box;
      s2_mx_q     <= s2_ctx_d.mx;
      s2_my_q     <= s2_ctx_d.my;
      s2_r_q      <= s2_r_d;
      s2_ctx_q    <= s2_ctx_d;
    end
  end

  // ---------------- stage 3: squares ----------------
  logic                 s3_v_q, s3_op_q, s3_inside_q;
  logic [2*MAG_W-1:0]   s3_xx_q, s3_yy_q;
  logic [65:0]          s3_rr_q;
  cmu_ctx_t             s3_ctx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_op_q     <= s2_op_q;
      s3_inside_q <= s2_inside_q;
      s3_xx_q     <= s2_mx_q * s2_mx_q;
      s3_yy_q     <= s2_my_q * s2_my_q;
      s3_rr_q     <= s2_r_q * s2_r_q;
      s3_ctx_q    <= s2_ctx_q;
    end
  end

  // ---------------- stage 4: sum and hit test ----------------
  logic [RAD_W-1:0] s4_sum;
  logic             s4_far;
  cmu_ctx_t         s4_ctx;

  always_comb begin
    s4_sum = RAD_W'(s3_xx_q) + RAD_W'(s3_yy_q);
    s4_far = s4_sum > RAD_W'(s3_rr_q);
    s4_ctx = s3_ctx_q;
    if (s3_op_q == OP_BOX) begin
      s4_ctx.hit = s3_inside_q || !s4_far;
    end else begin
      s4_ctx.hit = !s4_far;
    end
  end

  // ---------------- square root stages ----------------
  logic                sq_v_q    [SQ_N+1];
  logic [ROOT_W+2:0]   sq_rem_q  [SQ_N+1];
  logic [ROOT_W-1:0]   sq_root_q [SQ_N+1];
  logic [RAD_W-1:0]    sq_rad_q  [SQ_N+1];
  cmu_ctx_t            sq_ctx_q  [SQ_N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (en) begin
      sq_v_q[0] <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      sq_rad_q[0]  <= s4_sum;
      sq_ctx_q[0]  <= s4_ctx;
    end
  end

  for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
    logic [ROOT_W+2:0] cur, trial;
    logic              ge;

    // bring down two radicand bits, try root*4+1
    always_comb begin
      cur   = {sq_rem_q[g][ROOT_W:0], sq_rad_q[g][RAD_W-1 -: 2]};
      trial = {1'b0, sq_root_q[g], 2'b01};
      ge    = cur >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[g+1] <= 1'b0;
      end else if (en) begin
        sq_v_q[g+1] <= sq_v_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_rem_q[g+1]  <= ge ? cur - trial : cur;
        sq_root_q[g+1] <= {sq_root_q[g][ROOT_W-2:0], ge};
        sq_rad_q[g+1]  <= {sq_rad_q[g][RAD_W-3:0], 2'b00};
        sq_ctx_q[g+1]  <= sq_ctx_q[g];
      end
    end
  end

  // ---------------- divider stages ----------------
  logic              dv_v_q  [DV_N+1];
  logic [ROOT_W:0]   dv_rx_q [DV_N+1];
  logic [ROOT_W:0]   dv_ry_q [DV_N+1];
  logic [Q_W-1:0]    dv_qx_q [DV_N+1];
  logic [Q_W-1:0]    dv_qy_q [DV_N+1];
  logic [ROOT_W-1:0] dv_d_q  [DV_N+1];
  cmu_ctx_t          dv_ctx_q[DV_N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= sq_v_q[SQ_N];
    end
  end

  // numerator is |c| << 30; start with its bits above the quotient
  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_rx_q[0]  <= (ROOT_W+1)'(sq_ctx_q[SQ_N].mx >> 1);
      dv_ry_q[0]  <= (ROOT_W+1)'(sq_ctx_q[SQ_N].my >> 1);
      dv_qx_q[0]  <= '0;
      dv_qy_q[0]  <= '0;
      dv_d_q[0]   <= sq_root_q[SQ_N];
      dv_ctx_q[0] <= sq_ctx_q[SQ_N];
    end
  end

  for (genvar g = 0; g < DV_N; g++) begin : g_div
    logic [ROOT_W+1:0] tx_w, ty_w, dd;
    logic              gx, gy, bx, by;

    always_comb begin
      bx   = (g == 0) ? dv_ctx_q[g].mx[0] : 1'b0;
      by   = (g == 0) ? dv_ctx_q[g].my[0] : 1'b0;
      tx_w = {dv_rx_q[g], bx};
      ty_w = {dv_ry_q[g], by};
      dd   = {2'b00, dv_d_q[g]};
      gx   = tx_w >= dd;
      gy   = ty_w >= dd;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[g+1] <= 1'b0;
      end else if (en) begin
        dv_v_q[g+1] <= dv_v_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_rx_q[g+1]  <= (ROOT_W+1)'(gx ? tx_w - dd : tx_w);
        dv_ry_q[g+1]  <= (ROOT_W+1)'(gy ? ty_w - dd : ty_w);
        dv_qx_q[g+1]  <= {dv_qx_q[g][Q_W-2:0], gx};
        dv_qy_q[g+1]  <= {dv_qy_q[g][Q_W-2:0], gy};
        dv_d_q[g+1]   <= dv_d_q[g];
        dv_ctx_q[g+1] <= dv_ctx_q[g];
      end
    end
  end

  // ---------------- output register ----------------
  cmu_out_t           out_d, out_q;
  cmu_ctx_t           fc;
  logic [ROOT_W-1:0]  fd;
  logic signed [36:0] pen_w;
  logic signed [31:0] qx, qy;

  always_comb begin
    fc    = dv_ctx_q[DV_N];
    fd    = dv_d_q[DV_N];
    qx    = $signed({1'b0, dv_qx_q[DV_N]});
    qy    = $signed({1'b0, dv_qy_q[DV_N]});
    pen_w = $signed({4'b0000, fc.pen_r}) - $signed({2'b00, fd});
    out_d = '0;
    if (fc.hit) begin
      out_d.hit = 1'b1;
      if (fd == '0) begin
        out_d.normal_x    = fc.zx;
        out_d.normal_y    = fc.zy;
        out_d.penetration = $signed({1'b0, fc.zpen});
      end else begin
        out_d.normal_x = fc.sx ? -qx : qx;
        out_d.normal_y = fc.sy ? -qy : qy;
        // saturate depth to 32 bits
        if (pen_w > 37'sd2147483647) begin
          out_d.penetration = 32'sh7FFF_FFFF;
        end else if (pen_w < -37'sd2147483648) begin
          out_d.penetration = 32'sh8000_0000;
        end else begin
          out_d.penetration = pen_w[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v_q[DV_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire
